>>> rtl/hnm_pkg.sv
package hnm_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ADDR_W    = COL_W + 1;
   localparam int DEPTH     = 2 * MAX_WIDTH;
   localparam int WCMP_W    = (COL_W + 1 > 13) ? COL_W + 1 : 13;

   localparam logic [31:0] TILT_B  = 32'hFE01_0000;
   localparam logic [63:0] TILT_B2 = 64'(TILT_B) * 64'(TILT_B);

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HEIGHT_SCALE = 2'd2;

   localparam logic [4:0] STEP_MUL_A      = 5'd1;
   localparam logic [4:0] STEP_PART       = 5'd2;
   localparam logic [4:0] STEP_AC         = 5'd3;
   localparam logic [4:0] STEP_SB         = 5'd4;
   localparam logic [4:0] STEP_NUM        = 5'd5;
   localparam logic [4:0] STEP_ZSET       = 5'd6;
   localparam logic [4:0] STEP_Z_FIRST    = 5'd7;
   localparam logic [4:0] STEP_Z_LAST     = 5'd13;
   localparam logic [4:0] STEP_TILT_FIRST = 5'd3;
   localparam logic [4:0] STEP_TILT_LAST  = 5'd16;
   localparam logic [4:0] STEP_ROOT_FIRST = 5'd17;
   localparam logic [4:0] STEP_LAST       = 5'd23;

   localparam logic [1:0] RD_WEST  = 2'd0;
   localparam logic [1:0] RD_EAST  = 2'd1;
   localparam logic [1:0] RD_NORTH = 2'd2;
   localparam logic [1:0] RD_WRITE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CALC = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [COL_W-1:0] x;
      logic             yb;
      logic             flush;
      logic             rowend;
      logic             produce;
      logic             wok;
      logic             eok;
      logic             nok;
      logic [7:0]       sample;
   } item_type;

endpackage

>>> rtl/height_to_normal_map_core.sv
// An accepted pixel transaction reads its west, east and north neighbours from the
// line memory, writes its sample unless flushing, then runs the 24-step shared divide
// and root sequence; no new transaction is accepted until its result is loaded on rsp_.
// Transactions without a result skip the sequence; ignored pads are consumed in idle.
// Reset is synchronous: counters clear, registers load 4096, 1 and 256;
// the line memory is not cleared.
module height_to_normal_map_core import hnm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] height_sample
   input  logic [0:0]  req_tuser,   // [0] pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] normal_x, [15:8] normal_y, [23:16] normal_z
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [12:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] scale_ff, scale_in;
   item_type item_ff, item_in;
   logic [7:0] west_ff, west_in, east_ff, east_in, north_ff, north_in;
   logic sx_ff, sx_in, sy_ff, sy_in;
   logic [23:0] mx_ff, mx_in, my_ff, my_in;
   logic [47:0] a_ff, a_in, c_ff, c_in, g_ff, g_in;
   logic [47:0] pl_ff, pl_in, pm_ff, pm_in, ph_ff, ph_in;
   logic [95:0] ac_ff, ac_in;
   logic [80:0] sb_ff, sb_in;
   logic [95:0] numz_ff, numz_in;
   logic [97:0] denz_ff, denz_in;
   logic negz_ff, negz_in;
   logic [61:0] remx_ff, remx_in, dshx_ff, dshx_in, remy_ff, remy_in, dshy_ff, dshy_in;
   logic [13:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [6:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic [103:0] remz_ff, remz_in, dshz_ff, dshz_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;

   logic [7:0] row_mem [DEPTH];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic mem_we;

   logic req_fire;
   logic [WCMP_W-1:0] width_eff, col_next;
   logic [15:0] height_eff;
   logic flushing, row_end;
   logic [7:0] south, ux, uy;
   logic [48:0] denx, deny, sac;
   logic ge_x, ge_y, ge_z;
   logic [2:0] root_k;
   logic [6:0] trial_x, trial_y;
   logic [7:0] code_x, code_y, code_z;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (width_ff == 13'd0) begin
         width_eff = WCMP_W'(1);
      end else if (WCMP_W'(width_ff) > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = WCMP_W'(width_ff);
      end
      height_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
      col_next   = WCMP_W'(col_ff) + WCMP_W'(1);
      flushing   = (row_ff >= height_eff);
      row_end    = (col_next >= width_eff);
   end

   always_comb begin
      case (step_ff[1:0])
         RD_WEST: mem_addr = {~item_ff.yb, item_ff.x - COL_W'(1)};
         RD_EAST: mem_addr = {~item_ff.yb, item_ff.x + COL_W'(1)};
         default: mem_addr = {item_ff.yb, item_ff.x};
      endcase
      mem_we = (state_ff == ST_READ) && (step_ff[1:0] == RD_WRITE) && !item_ff.flush;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_addr] <= item_ff.sample;
      end
      rd_data_ff <= row_mem[mem_addr];
   end

   always_comb begin
      south   = item_ff.flush ? 8'd0 : item_ff.sample;
      ux      = (west_ff < east_ff) ? east_ff - west_ff : west_ff - east_ff;
      uy      = (south < north_ff) ? north_ff - south : south - north_ff;
      denx    = 49'(a_ff) + 49'(TILT_B);
      deny    = 49'(c_ff) + 49'(TILT_B);
      sac     = 49'(a_ff) + 49'(c_ff);
      ge_x    = (remx_ff >= dshx_ff);
      ge_y    = (remy_ff >= dshy_ff);
      ge_z    = (remz_ff >= dshz_ff);
      root_k  = 3'(STEP_LAST - step_ff);
      trial_x = qx_ff | (7'd1 << root_k);
      trial_y = qy_ff | (7'd1 << root_k);
      code_x  = sx_ff ? 8'd128 - 8'(qx_ff) : 8'd128 + 8'(qx_ff);
      code_y  = sy_ff ? 8'd128 - 8'(qy_ff) : 8'd128 + 8'(qy_ff);
      code_z  = negz_ff ? 8'd128 - 8'(qz_ff) : 8'd128 + 8'(qz_ff);
   end

   always_comb begin
      state_in = state_ff;   step_in = step_ff;   col_in = col_ff;   row_in = row_ff;
      width_in = width_ff;   height_in = height_ff;   scale_in = scale_ff;
      item_in = item_ff;   west_in = west_ff;   east_in = east_ff;   north_in = north_ff;
      sx_in = sx_ff;   sy_in = sy_ff;   mx_in = mx_ff;   my_in = my_ff;
      a_in = a_ff;   c_in = c_ff;   g_in = g_ff;   pl_in = pl_ff;   pm_in = pm_ff;
      ph_in = ph_ff;   ac_in = ac_ff;   sb_in = sb_ff;   numz_in = numz_ff;
      denz_in = denz_ff;   negz_in = negz_ff;   remx_in = remx_ff;   dshx_in = dshx_ff;
      remy_in = remy_ff;   dshy_in = dshy_ff;   rx_in = rx_ff;   ry_in = ry_ff;
      qx_in = qx_ff;   qy_in = qy_ff;   qz_in = qz_ff;   remz_in = remz_ff;
      dshz_in = dshz_ff;   rsp_data_in = rsp_data_ff;   rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data[12:0];
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            CSR_HEIGHT_SCALE: scale_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (flushing || !req_tuser[0])) begin
               item_in.x       = col_ff;
               item_in.yb      = row_ff[0];
               item_in.flush   = flushing;
               item_in.rowend  = row_end;
               item_in.produce = flushing || (row_ff != 16'd0);
               item_in.wok     = (col_ff != '0);
               item_in.eok     = !row_end;
               item_in.nok     = (row_ff >= 16'd2);
               item_in.sample  = req_tdata;
               if (row_end) begin
                  col_in = '0;
                  row_in = flushing ? 16'd0 : row_ff + 16'd1;
               end else begin
                  col_in = col_next[COL_W-1:0];
               end
               state_in = ST_READ;
               step_in  = 5'd0;
            end
         end
         ST_READ: begin
            step_in = step_ff + 5'd1;
            case (step_ff[1:0])
               RD_EAST:  west_in = item_ff.wok ? rd_data_ff : 8'd0;
               RD_NORTH: east_in = item_ff.eok ? rd_data_ff : 8'd0;
               RD_WRITE: begin
                  north_in = item_ff.nok ? rd_data_ff : 8'd0;
                  step_in  = 5'd0;
                  state_in = item_ff.produce ? ST_CALC : ST_IDLE;
               end
               default: ;
            endcase
         end
         ST_CALC: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd0) begin
               sx_in = (west_ff < east_ff);
               sy_in = (south < north_ff);
               mx_in = 24'(ux) * 24'(scale_ff);
               my_in = 24'(uy) * 24'(scale_ff);
            end
            if (step_ff == STEP_MUL_A) begin
               a_in = 48'(mx_ff) * 48'(mx_ff);
               c_in = 48'(my_ff) * 48'(my_ff);
               g_in = 48'(mx_ff) * 48'(my_ff);
            end
            if (step_ff == STEP_PART) begin
               pl_in   = 48'(g_ff[23:0]) * 48'(g_ff[23:0]);
               pm_in   = 48'(g_ff[47:24]) * 48'(g_ff[23:0]);
               ph_in   = 48'(g_ff[47:24]) * 48'(g_ff[47:24]);
               remx_in = (62'(a_ff) << 14) - (62'(a_ff) << 8) + 62'(a_ff);
               remy_in = (62'(c_ff) << 14) - (62'(c_ff) << 8) + 62'(c_ff);
               dshx_in = {denx, 13'd0};
               dshy_in = {deny, 13'd0};
               rx_in   = '0;
               ry_in   = '0;
               qx_in   = '0;
               qy_in   = '0;
            end
            if (step_ff == STEP_AC) begin
               ac_in = (96'(ph_ff) << 48) + (96'(pm_ff) << 25) + 96'(pl_ff);
            end
            if (step_ff == STEP_SB) begin
               sb_in = (81'(sac) << 32) - (81'(sac) << 25) + (81'(sac) << 16);
            end
            if (step_ff == STEP_NUM) begin
               negz_in = (ac_ff > 96'(TILT_B2));
               numz_in = (ac_ff > 96'(TILT_B2)) ? ac_ff - 96'(TILT_B2)
                                                : 96'(TILT_B2) - ac_ff;
               denz_in = 98'(ac_ff) + 98'(sb_ff) + 98'(TILT_B2);
            end
            if (step_ff == STEP_ZSET) begin
               remz_in = (104'(numz_ff) << 7) - 104'(numz_ff);
               dshz_in = {denz_ff, 6'd0};
               qz_in   = '0;
            end
            if (step_ff >= STEP_Z_FIRST && step_ff <= STEP_Z_LAST) begin
               remz_in = ge_z ? remz_ff - dshz_ff : remz_ff;
               dshz_in = dshz_ff >> 1;
               qz_in   = {qz_ff[5:0], ge_z};
            end
            if (step_ff >= STEP_TILT_FIRST && step_ff <= STEP_TILT_LAST) begin
               remx_in = ge_x ? remx_ff - dshx_ff : remx_ff;
               remy_in = ge_y ? remy_ff - dshy_ff : remy_ff;
               dshx_in = dshx_ff >> 1;
               dshy_in = dshy_ff >> 1;
               rx_in   = {rx_ff[12:0], ge_x};
               ry_in   = {ry_ff[12:0], ge_y};
            end
            if (step_ff >= STEP_ROOT_FIRST) begin
               if (14'(trial_x) * 14'(trial_x) <= rx_ff) begin
                  qx_in = trial_x;
               end
               if (14'(trial_y) * 14'(trial_y) <= ry_ff) begin
                  qy_in = trial_y;
               end
            end
            if (step_ff == STEP_LAST) begin
               step_in  = 5'd0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {code_z, code_y, code_x};
               rsp_last_in  = item_ff.flush && item_ff.rowend;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 5'd0;
         col_ff       <= '0;
         row_ff       <= 16'd0;
         width_ff     <= 13'd4096;
         height_ff    <= 16'd1;
         scale_ff     <= 16'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;   west_ff <= west_in;   east_ff <= east_in;   north_ff <= north_in;
      sx_ff <= sx_in;   sy_ff <= sy_in;   mx_ff <= mx_in;   my_ff <= my_in;
      a_ff <= a_in;   c_ff <= c_in;   g_ff <= g_in;   pl_ff <= pl_in;   pm_ff <= pm_in;
      ph_ff <= ph_in;   ac_ff <= ac_in;   sb_ff <= sb_in;   numz_ff <= numz_in;
      denz_ff <= denz_in;   negz_ff <= negz_in;   remx_ff <= remx_in;   dshx_ff <= dshx_in;
      remy_ff <= remy_in;   dshy_ff <= dshy_in;   rx_ff <= rx_in;   ry_ff <= ry_in;
      qx_ff <= qx_in;   qy_ff <= qy_in;   qz_ff <= qz_in;   remz_ff <= remz_in;
      dshz_ff <= dshz_in;   rsp_data_ff <= rsp_data_in;   rsp_last_ff <= rsp_last_in;
   end

   a_tilt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> rx_ff <= 14'd16129 && ry_ff <= 14'd16129)
      else $error("tilt quotient out of range");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> step_ff <= STEP_LAST)
      else $error("sequencer step overrun");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside done state");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_fire && (flushing || !req_tuser[0]) |=> state_ff == ST_READ && step_ff == 5'd0)
      else $error("accepted transaction not sequenced");

endmodule

>>> tb/tb_height_to_normal_map_core.sv
`timescale 1ns / 100ps

module tb_height_to_normal_map_core;
   import hnm_pkg::*;

   typedef struct {
      logic [7:0] nx;
      logic [7:0] ny;
      logic [7:0] nz;
      logic       last;
   } normal_type;

   typedef struct {
      logic       is_cfg;
      logic [1:0] idx;
      logic [15:0] val;
      logic [7:0] sample;
      logic       pad;
      logic       typed;
      normal_type res;
   } stim_row_type;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   height_to_normal_map_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic [12:0] cfg_width;
   logic [15:0] cfg_height;
   logic [15:0] cfg_scale;
   logic [7:0]  line_rows [0:2*MAX_WIDTH-1];
   int unsigned col_pos;
   int unsigned row_pos;

   normal_type pending_normals[$];
   int errors;
   int mismatches;
   int results_seen;
   int items_sent;
   int frames_done;
   int cycles;
   int mode;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [127:0] scaled_square(int d);
      logic [127:0] m;
      m = 128'(d < 0 ? -d : d) * 128'(cfg_scale);
      return m * m;
   endfunction

   function automatic logic [7:0] tilt_code(int d);
      logic [127:0] a;
      logic [127:0] den;
      logic [127:0] lim;
      int q;
      a = scaled_square(d);
      den = a + 128'd65280 * 128'd65280;
      lim = 128'd16129 * a;
      q = 0;
      while (q < 127 && 128'((q + 1) * (q + 1)) * den <= lim)
         q++;
      return d < 0 ? 8'(128 - q) : 8'(128 + q);
   endfunction

   function automatic logic [7:0] up_code(int dx, int dy);
      logic [127:0] a;
      logic [127:0] c;
      logic [127:0] b;
      logic [127:0] den;
      logic [127:0] num;
      logic [127:0] target;
      logic [127:0] acc;
      logic neg;
      int q;
      a = scaled_square(dx);
      c = scaled_square(dy);
      b = 128'd65280 * 128'd65280;
      den = (a + b) * (c + b);
      neg = a * c > b * b;
      num = neg ? a * c - b * b : b * b - a * c;
      target = num * 128'd127;
      acc = '0;
      q = 0;
      while (q < 127 && acc + den <= target) begin
         acc = acc + den;
         q++;
      end
      return neg ? 8'(128 - q) : 8'(128 + q);
   endfunction

   function automatic logic [7:0] line_at(int unsigned r, int unsigned x);
      return line_rows[((r & 1) * MAX_WIDTH + x) % (2 * MAX_WIDTH)];
   endfunction

   // advance the predictor by one accepted transaction
   function automatic logic predict_normal(logic [7:0] sample, logic pad,
                                           output normal_type res);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      int unsigned west;
      int unsigned east;
      int unsigned north;
      int unsigned south;
      logic flushing;
      logic row_end;
      logic produce;
      w = cfg_width == 0 ? 1 : cfg_width;
      h = cfg_height == 0 ? 1 : cfg_height;
      if (w > MAX_WIDTH)
         w = MAX_WIDTH;
      x = col_pos;
      y = row_pos;
      flushing = y >= h;
      res = '{8'd0, 8'd0, 8'd0, 1'b0};
      if (!flushing && pad)
         return 1'b0;
      row_end = x + 1 >= w;
      produce = flushing || y >= 1;
      north = 0;
      south = 0;
      if (produce) begin
         west = x > 0 ? line_at(y - 1, x - 1) : 0;
         east = !row_end ? line_at(y - 1, x + 1) : 0;
         if (y >= 2)
            north = line_at(y - 2, x);
         if (!flushing)
            south = sample;
         res.nx = tilt_code(int'(west) - int'(east));
         res.ny = tilt_code(int'(south) - int'(north));
         res.nz = up_code(int'(west) - int'(east), int'(south) - int'(north));
         res.last = flushing && row_end;
      end
      if (!flushing)
         line_rows[((y & 1) * MAX_WIDTH + x) % (2 * MAX_WIDTH)] = sample;
      if (row_end) begin
         col_pos = 0;
         row_pos = flushing ? 0 : ((y + 1) & 16'hFFFF);
      end else begin
         col_pos = x + 1;
      end
      return produce;
   endfunction

   function automatic logic roll(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_normals.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            cfg_width = val[12:0];
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = val;
         end
         CSR_HEIGHT_SCALE: begin
            cfg_scale = val;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // send one transaction; a typed result replaces the predicted one
   task automatic push_height(logic [7:0] sample, logic pad, logic typed,
                              normal_type typed_res);
      normal_type res;
      @(negedge clock);
      while (roll(mode == 1 ? 67 : mode == 3 ? 10 : 0)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= pad;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (predict_normal(sample, pad, res))
         pending_normals.push_back(typed ? typed_res : res);
   endtask

   task automatic run_frame(int w, int h, int noise_pct);
      normal_type dummy;
      dummy = '{8'd0, 8'd0, 8'd0, 1'b0};
      for (int i = 0; i < w * h; i++) begin
         while (roll(noise_pct))
            push_height(8'($urandom), 1'b1, 1'b0, dummy);
         push_height(roll(15) ? (roll(50) ? 8'd255 : 8'd0) : 8'($urandom),
                     1'b0, 1'b0, dummy);
      end
      for (int i = 0; i < w; i++)
         push_height(8'($urandom), 1'($urandom), 1'b0, dummy);
      frames_done++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !roll(mode == 2 ? 67 : mode == 3 ? 10 : 0);
   end

   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_normals.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_normals.pop_front();
            if (rsp_tdata[7:0] !== want.nx || rsp_tdata[15:8] !== want.ny ||
                rsp_tdata[23:16] !== want.nz || rsp_tlast !== want.last) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x %0d y %0d z %0d last %b, got x %0d y %0d z %0d last %b",
                           want.nx, want.ny, want.nz, want.last, rsp_tdata[7:0],
                           rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   stim_row_type directed [$];

   function automatic stim_row_type cfg_row(logic [1:0] idx, logic [15:0] val);
      return '{1'b1, idx, val, 8'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}};
   endfunction

   function automatic stim_row_type px_row(logic [7:0] s, logic p, logic t,
                                           logic [7:0] x, logic [7:0] y,
                                           logic [7:0] z, logic l);
      return '{1'b0, CSR_IMAGE_WIDTH, 16'd0, s, p, t, '{x, y, z, l}};
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_data = '0;
      cfg_width = 13'd4096;
      cfg_height = 16'd1;
      cfg_scale = 16'd256;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 2 * MAX_WIDTH; i++)
         line_rows[i] = 8'd0;
      errors = 0;
      mismatches = 0;
      results_seen = 0;
      items_sent = 0;
      frames_done = 0;
      cycles = 0;
      mode = 0;

      // flat zero image, ignored pad, sample during flush
      directed.push_back(cfg_row(CSR_IMAGE_WIDTH, 16'd2));
      directed.push_back(cfg_row(CSR_IMAGE_HEIGHT, 16'd2));
      directed.push_back(px_row(8'd0, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b1, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b0, 1'b1, 128, 128, 255, 0));
      directed.push_back(px_row(8'd0, 1'b0, 1'b1, 128, 128, 255, 0));
      directed.push_back(px_row(8'd77, 1'b0, 1'b1, 128, 128, 255, 0));
      directed.push_back(px_row(8'd0, 1'b1, 1'b1, 128, 128, 255, 1));
      // steepest slopes at the largest scale
      directed.push_back(cfg_row(CSR_HEIGHT_SCALE, 16'hFFFF));
      directed.push_back(cfg_row(CSR_IMAGE_WIDTH, 16'd3));
      directed.push_back(px_row(8'd255, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd255, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd255, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b1, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd170, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b1, 1'b0, 0, 0, 0, 0));
      // zero scale, width and height of zero count as one
      directed.push_back(cfg_row(CSR_HEIGHT_SCALE, 16'd0));
      directed.push_back(cfg_row(CSR_IMAGE_WIDTH, 16'd0));
      directed.push_back(cfg_row(CSR_IMAGE_HEIGHT, 16'd0));
      directed.push_back(px_row(8'd255, 1'b0, 1'b0, 0, 0, 0, 0));
      directed.push_back(px_row(8'd0, 1'b1, 1'b1, 128, 128, 255, 1));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_cfg)
            write_csr(directed[i].idx, directed[i].val);
         else
            push_height(directed[i].sample, directed[i].pad, directed[i].typed,
                        directed[i].res);
      end

      while (items_sent < 1000) begin
         int w;
         int h;
         int pick;
         w = $urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         pick = $urandom_range(0, 3);
         write_csr(CSR_IMAGE_WIDTH, 16'(w));
         write_csr(CSR_IMAGE_HEIGHT, 16'(h));
         write_csr(CSR_HEIGHT_SCALE, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
                                     pick == 2 ? 16'd256 : 16'($urandom));
         mode = frames_done % 5 == 4 ? 0 : frames_done % 4;
         run_frame(w, h, 10);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_normals.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d transactions, %0d frames, %0d results checked",
               items_sent, frames_done, results_seen);
      $display("errors %0d (mismatches %0d)", errors, mismatches);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
rtl/hnm_pkg.sv
rtl/height_to_normal_map_core.sv
tb/tb_height_to_normal_map_core.sv
